// File: hw/rtl/gravity_average_per_photo_macros.svh
// Assertion macros shared by the gravity average block.
`ifndef GRAVITY_AVERAGE_PER_PHOTO_MACROS_SVH
`define GRAVITY_AVERAGE_PER_PHOTO_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GAP_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gap assertion failed");

// Next-cycle implication, disabled during reset.
`define GAP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gap assertion failed");

`endif

// File: hw/rtl/gap_pkg.sv
// Package: constants, codes and controller/datapath types for the gravity average block.
package gap_pkg;

    localparam int MAX_SKIP_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SUM_BITS_DEF    = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHOTOS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QZ     = 3'd6;

    localparam logic [1:0] CMD_SESSION = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_PHOTO   = 2'd2;

    localparam int IDX_W = 6;

    typedef struct packed {
        logic             acc_sess;
        logic             acc_samp;
        logic             acc_photo;
        logic             samp_add;
        logic             norm;
        logic             sq;
        logic             sqrt;
        logic             div;
        logic             qp;
        logic             rot;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic zero;
        logic norm_ok;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/gap_in_if.sv
// Input event channel.
interface gap_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic signed [SAMPLE_BITS-1:0] grav_x;
    logic signed [SAMPLE_BITS-1:0] grav_y;
    logic signed [SAMPLE_BITS-1:0] grav_z;

    modport source (output valid, command, grav_x, grav_y, grav_z, input ready);
    modport sink   (input valid, command, grav_x, grav_y, grav_z, output ready);
endinterface

// File: hw/rtl/gap_out_if.sv
// Result channel.
interface gap_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         photo_number;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic               status;

    modport source (output valid, photo_number, unit_x, unit_y, unit_z, status, input ready);
    modport sink   (input valid, photo_number, unit_x, unit_y, unit_z, status, output ready);
endinterface

// File: hw/rtl/gap_ctrl.sv
// Controller: sequences sample accumulation and the photo normalize/rotate pass.
module gap_ctrl
    import gap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    output logic       o_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADD  = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_QP   = 4'd6;
    localparam logic [3:0] S_ROT  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [IDX_W-1:0] LAST_SQ   = 6'd3;
    localparam logic [IDX_W-1:0] LAST_SQRT = 6'd31;
    localparam logic [IDX_W-1:0] LAST_DIV  = 6'd15;
    localparam logic [IDX_W-1:0] LAST_QP   = 6'd8;
    localparam logic [IDX_W-1:0] LAST_ROT  = 6'd9;

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx + 1'b1;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_idx   = '0;
                if (i_valid) begin
                    unique case (i_command)
                        CMD_SESSION: o_cmd.acc_sess = 1'b1;
                        CMD_SAMPLE: begin
                            o_cmd.acc_samp = 1'b1;
                            n_state = S_ADD;
                        end
                        CMD_PHOTO: begin
                            o_cmd.acc_photo = 1'b1;
                            if (i_stat.match) begin
                                n_state = i_stat.zero ? S_OUT : S_NORM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.samp_add = 1'b1;
                n_state = S_IDLE;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_idx = '0;
                if (i_stat.norm_ok) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                if (r_idx == LAST_SQ) begin
                    n_state = S_SQRT;
                    n_idx = '0;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt = 1'b1;
                if (r_idx == LAST_SQRT) begin
                    n_state = S_DIV;
                    n_idx = '0;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (r_idx == LAST_DIV) begin
                    n_state = S_QP;
                    n_idx = '0;
                end
            end
            S_QP: begin
                o_cmd.qp = 1'b1;
                if (r_idx == LAST_QP) begin
                    n_state = S_ROT;
                    n_idx = '0;
                end
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                if (r_idx == LAST_ROT) begin
                    n_state = S_OUT;
                    n_idx = '0;
                end
            end
            S_OUT: begin
                n_idx = '0;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/gap_dp.sv
// Datapath: config registers, delay ring, sums, normalize, square root, divide, rotation.
`include "gravity_average_per_photo_macros.svh"
module gap_dp
    import gap_pkg::*;
#(
    parameter int MAX_SKIP    = MAX_SKIP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_grav_x,
    input  logic signed [SAMPLE_BITS-1:0] i_grav_y,
    input  logic signed [SAMPLE_BITS-1:0] i_grav_z,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [7:0]                    o_photo_number,
    output logic signed [15:0]            o_unit_x,
    output logic signed [15:0]            o_unit_y,
    output logic signed [15:0]            o_unit_z,
    output logic                          o_status
);

    localparam int PW    = (MAX_SKIP > 1) ? $clog2(MAX_SKIP) : 1;
    localparam int SKW   = $clog2(MAX_SKIP + 1);
    localparam int AW    = SKW + 1;
    localparam int WW    = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 1;
    localparam int MAGW  = (SUM_BITS > 30) ? SUM_BITS : 31;
    localparam int SMPW  = 3 * SAMPLE_BITS;

    // configuration
    logic [7:0]         r_target, r_photos;
    logic [4:0]         r_skip;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 8'd0;
            r_skip   <= 5'd0;
            r_photos <= 8'd255;
            r_qw     <= 16'sd16384;
            r_qx     <= '0;
            r_qy     <= '0;
            r_qz     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: r_target <= i_cfg_data[7:0];
                CFG_SKIP:   r_skip   <= i_cfg_data[4:0];
                CFG_PHOTOS: r_photos <= i_cfg_data[7:0];
                CFG_QW:     r_qw     <= i_cfg_data;
                CFG_QX:     r_qx     <= i_cfg_data;
                CFG_QY:     r_qy     <= i_cfg_data;
                CFG_QZ:     r_qz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // event state
    logic [8:0]                 r_session;
    logic [7:0]                 r_pctr;
    logic [PW-1:0]              r_ptr;
    logic [SKW-1:0]             r_cnt;
    logic signed [SUM_BITS-1:0] r_sum [3];
    logic [SMPW-1:0]            r_ring [MAX_SKIP];
    logic [SMPW-1:0]            r_smp, r_rd;

    logic [SKW-1:0] skip;
    logic [AW-1:0]  raddr_w;
    logic [PW-1:0]  raddr;
    logic [SMPW-1:0] add_v;
    logic signed [SUM_BITS-1:0] sum_n [3];
    logic clear;

    assign skip = (32'(r_skip) > MAX_SKIP) ? SKW'(MAX_SKIP) : SKW'(r_skip);

    always_comb begin
        raddr_w = AW'(r_ptr) + AW'(MAX_SKIP) - AW'(skip);
        if (raddr_w >= AW'(MAX_SKIP)) begin
            raddr_w = raddr_w - AW'(MAX_SKIP);
        end
        raddr = raddr_w[PW-1:0];
    end

    assign add_v = (skip == '0) ? r_smp : r_rd;

    always_comb begin
        logic signed [WW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            t = WW'(r_sum[i]) + WW'($signed(add_v[i*SAMPLE_BITS +: SAMPLE_BITS]));
            if (t > $signed(WW'({1'b0, {(SUM_BITS-1){1'b1}}}))) begin
                sum_n[i] = {1'b0, {(SUM_BITS-1){1'b1}}};
            end else if (t < $signed({{(WW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}})) begin
                sum_n[i] = {1'b1, {(SUM_BITS-1){1'b0}}};
            end else begin
                sum_n[i] = t[SUM_BITS-1:0];
            end
        end
    end

    assign clear = i_cmd.acc_sess || i_cmd.acc_photo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_samp) begin
            r_rd  <= r_ring[raddr];
            r_smp <= {i_grav_z, i_grav_y, i_grav_x};
        end
        if (i_cmd.samp_add) begin
            r_ring[r_ptr] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session <= 9'h1FF;
            r_pctr    <= '0;
            r_ptr     <= '0;
            r_cnt     <= '0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
        end else begin
            if (i_cmd.acc_sess) begin
                r_session <= r_session + 9'd1;
                r_pctr    <= '0;
            end
            if (i_cmd.acc_photo && r_pctr != 8'd255) begin
                r_pctr <= r_pctr + 8'd1;
            end
            if (clear) begin
                r_cnt <= '0;
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            end
            if (i_cmd.samp_add) begin
                if (r_cnt >= skip) begin
                    for (int i = 0; i < 3; i++) r_sum[i] <= sum_n[i];
                end
                r_ptr <= (r_ptr == PW'(MAX_SKIP - 1)) ? '0 : r_ptr + 1'b1;
                if (r_cnt < SKW'(MAX_SKIP)) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // photo pass
    logic [MAGW-1:0] r_mag [3];
    logic [2:0]      r_neg;
    logic            r_zero, r_err;
    logic [7:0]      r_pnum;
    logic [MAGW-1:0] m_or;
    logic [59:0]     r_prod;
    logic [63:0]     r_nsq;
    logic [34:0]     r_rem;
    logic [31:0]     r_root;
    logic [44:0]     r_drem [3];
    logic [45:0]     r_dsh;
    logic [14:0]     r_q [3];
    logic signed [31:0] r_qp [9];
    logic signed [49:0] r_rp;
    logic [1:0]      r_rrow;
    logic signed [51:0] r_acc [3];

    assign m_or = r_mag[0] | r_mag[1] | r_mag[2];

    assign o_stat.match    = (r_session == {1'b0, r_target});
    assign o_stat.zero     = (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0);
    assign o_stat.norm_ok  = m_or[29] && !(|m_or[MAGW-1:30]);
    assign o_stat.out_free = !o_out_valid || i_out_ready;

    logic [29:0] sq_sel;
    always_comb begin
        case (i_cmd.idx[1:0])
            2'd0:    sq_sel = r_mag[0][29:0];
            2'd1:    sq_sel = r_mag[1][29:0];
            default: sq_sel = r_mag[2][29:0];
        endcase
    end

    logic [34:0] rem_t, trial;
    always_comb begin
        logic [34:0] rc;
        logic [31:0] oc;
        rc    = (i_cmd.idx == '0) ? '0 : r_rem;
        oc    = (i_cmd.idx == '0) ? '0 : r_root;
        rem_t = {rc[32:0], r_nsq[63:62]};
        trial = {1'b0, oc, 2'b01};
    end

    logic signed [15:0] qa, qb;
    always_comb begin
        case (i_cmd.idx[3:0])
            4'd0:    begin qa = r_qy; qb = r_qy; end
            4'd1:    begin qa = r_qz; qb = r_qz; end
            4'd2:    begin qa = r_qx; qb = r_qx; end
            4'd3:    begin qa = r_qx; qb = r_qy; end
            4'd4:    begin qa = r_qz; qb = r_qw; end
            4'd5:    begin qa = r_qx; qb = r_qz; end
            4'd6:    begin qa = r_qy; qb = r_qw; end
            4'd7:    begin qa = r_qy; qb = r_qz; end
            default: begin qa = r_qx; qb = r_qw; end
        endcase
    end

    logic signed [15:0] u [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u[i] = r_neg[i] ? -$signed({1'b0, r_q[i]}) : $signed({1'b0, r_q[i]});
        end
    end

    // rotation entry for step idx: products are yy zz xx xy zw xz yw yz xw
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
    logic signed [33:0] ent;
    logic signed [15:0] ug;
    logic [1:0]         row;
    always_comb begin
        logic signed [33:0] p [9];
        for (int k = 0; k < 9; k++) p[k] = 34'(r_qp[k]);
        case (i_cmd.idx[3:0])
            4'd0: begin ent = ONE_Q28 - 2 * (p[0] + p[1]); ug = u[0]; row = 2'd0; end
            4'd1: begin ent = 2 * (p[3] - p[4]);           ug = u[1]; row = 2'd0; end
            4'd2: begin ent = 2 * (p[5] + p[6]);           ug = u[2]; row = 2'd0; end
            4'd3: begin ent = 2 * (p[3] + p[4]);           ug = u[0]; row = 2'd1; end
            4'd4: begin ent = ONE_Q28 - 2 * (p[2] + p[1]); ug = u[1]; row = 2'd1; end
            4'd5: begin ent = 2 * (p[7] - p[8]);           ug = u[2]; row = 2'd1; end
            4'd6: begin ent = 2 * (p[5] - p[6]);           ug = u[0]; row = 2'd2; end
            4'd7: begin ent = 2 * (p[7] + p[8]);           ug = u[1]; row = 2'd2; end
            default: begin ent = ONE_Q28 - 2 * (p[2] + p[0]); ug = u[2]; row = 2'd2; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_photo) begin
            r_zero <= o_stat.zero;
            r_pnum <= r_pctr;
            r_err  <= (r_pctr >= r_photos);
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_sum[i][SUM_BITS-1];
                r_mag[i] <= MAGW'($unsigned(r_sum[i][SUM_BITS-1] ? -r_sum[i] : r_sum[i]));
            end
        end
        if (i_cmd.norm && !o_stat.norm_ok) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= (|m_or[MAGW-1:30]) ? (r_mag[i] >> 1) : (r_mag[i] << 1);
            end
        end
        if (i_cmd.sq) begin
            r_prod <= sq_sel * sq_sel;
            r_nsq  <= (i_cmd.idx == '0) ? '0 : r_nsq + 64'(r_prod);
        end
        if (i_cmd.sqrt) begin
            r_nsq <= r_nsq << 2;
            if (rem_t >= trial) begin
                r_rem  <= rem_t - trial;
                r_root <= {(i_cmd.idx == '0) ? 31'd0 : r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_t;
                r_root <= {(i_cmd.idx == '0) ? 31'd0 : r_root[30:0], 1'b0};
            end
        end
        if (i_cmd.div) begin
            if (i_cmd.idx == '0) begin
                r_dsh <= {r_root, 14'd0};
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= {1'b0, r_mag[i][29:0], 14'd0} + 45'(r_root >> 1);
                end
            end else begin
                r_dsh <= r_dsh >> 1;
                for (int i = 0; i < 3; i++) begin
                    if ({1'b0, r_drem[i]} >= r_dsh) begin
                        r_drem[i] <= 45'({1'b0, r_drem[i]} - r_dsh);
                        r_q[i]    <= {r_q[i][13:0], 1'b1};
                    end else begin
                        r_q[i]    <= {r_q[i][13:0], 1'b0};
                    end
                end
            end
        end
        if (i_cmd.qp) begin
            r_qp[i_cmd.idx[3:0]] <= qa * qb;
        end
        if (i_cmd.rot) begin
            if (i_cmd.idx != 6'd9) begin
                r_rp   <= ent * ug;
                r_rrow <= row;
            end
            if (i_cmd.idx == '0) begin
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            end else begin
                r_acc[r_rrow] <= r_acc[r_rrow] + 52'(r_rp);
            end
        end
    end

    // output register
    logic signed [15:0] res [3];
    always_comb begin
        logic signed [51:0] t;
        for (int i = 0; i < 3; i++) begin
            t = (r_acc[i] + 52'sd134217728) >>> 28;
            if (t > 52'sd16384)       res[i] = 16'sd16384;
            else if (t < -52'sd16384) res[i] = -16'sd16384;
            else                      res[i] = t[15:0];
            if (r_zero) res[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_photo_number <= r_pnum;
            o_unit_x       <= res[0];
            o_unit_y       <= res[1];
            o_unit_z       <= res[2];
            o_status       <= r_err;
        end
    end

    `GAP_ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= SKW'(MAX_SKIP))
    `GAP_ASSERT_NEXT(a_sess_clears, i_clk, i_rst_n, i_cmd.acc_sess, r_sum[0] == '0 && r_cnt == '0)
    `GAP_ASSERT_IMPLY(a_norm_top, i_clk, i_rst_n, i_cmd.sq, r_mag[0] <= 31'h3FFFFFFF && m_or[29])
    `GAP_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, i_cmd.out_load, o_stat.out_free)

endmodule

// File: hw/rtl/gravity_average_per_photo.sv
// Top level: gravity average per photo, controller plus datapath.
// Session, unselected photo and unused events are taken in the idle state; a sample also passes an add state.
// A selected photo goes, after its transfer, through normalize shifts, square, root, divide,
// product and rotate steps to the load; if the sum is zero it goes straight to the load.
// Input waits until the result register is free; the root and divider set the photo pace.
// Synchronous active-low reset clears control state; the sample ring is not cleared.
module gravity_average_per_photo
    import gap_pkg::*;
#(
    parameter int MAX_SKIP    = MAX_SKIP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gap_in_if.sink                i_in,
    gap_out_if.source             o_out
);

    t_cmd  cmd;
    t_stat stat;

    gap_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .o_ready   (i_in.ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    gap_dp #(
        .MAX_SKIP    (MAX_SKIP),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_grav_x       (i_in.grav_x),
        .i_grav_y       (i_in.grav_y),
        .i_grav_z       (i_in.grav_z),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_photo_number (o_out.photo_number),
        .o_unit_x       (o_out.unit_x),
        .o_unit_y       (o_out.unit_y),
        .o_unit_z       (o_out.unit_z),
        .o_status       (o_out.status)
    );

endmodule

// File: verif/gravity_average_per_photo_tb.sv
// Testbench for gravity_average_per_photo: event stream stimulus checked against a predictor.
module gravity_average_per_photo_tb
    import gap_pkg::*;
();

    typedef struct packed {
        logic [7:0]         photo_number;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               status;
    } t_photo_vec;

    class gravity_scoreboard;
        longint ring [16][3];
        int unsigned ring_ptr;
        int unsigned n_samples;
        longint acc [3];
        int unsigned session_no;
        int unsigned photo_idx;
        int unsigned tgt_session, skip_n, n_photos;
        longint q [4];
        t_photo_vec pending [$];
        int errors;

        function new();
            foreach (ring[i, j]) ring[i][j] = 0;
            ring_ptr = 0;
            n_samples = 0;
            acc[0] = 0; acc[1] = 0; acc[2] = 0;
            session_no = 9'h1FF;
            photo_idx = 0;
            tgt_session = 0;
            skip_n = 0;
            n_photos = 255;
            q[0] = 16384; q[1] = 0; q[2] = 0; q[3] = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_TARGET: tgt_session = val[7:0];
                CFG_SKIP:   skip_n = val[4:0];
                CFG_PHOTOS: n_photos = val[7:0];
                CFG_QW:     q[0] = longint'($signed(val));
                CFG_QX:     q[1] = longint'($signed(val));
                CFG_QY:     q[2] = longint'($signed(val));
                CFG_QZ:     q[3] = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned sqrt_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint to_q14(longint v);
            longint r;
            r = (v + (64'sd1 << 27)) >>> 28;
            if (r > 16384) r = 16384;
            if (r < -16384) r = -16384;
            return r;
        endfunction

        function t_photo_vec predict_photo();
            longint unsigned mag [3];
            bit neg [3];
            longint unsigned mx, nsq, n;
            longint u [3], m [3][3], o [3];
            longint w, x, y, z, one;
            int len;
            t_photo_vec r;
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = acc[i] < 0;
                mag[i] = neg[i] ? -acc[i] : acc[i];
                if (mag[i] > mx) mx = mag[i];
            end
            if (mx == 0) begin
                u[0] = 0; u[1] = 0; u[2] = 0;
            end else begin
                len = 0;
                while (len < 63 && (mx >> len) != 0) len++;
                nsq = 0;
                for (int i = 0; i < 3; i++) begin
                    if (len > 30) mag[i] >>= (len - 30);
                    else mag[i] <<= (30 - len);
                    nsq += mag[i] * mag[i];
                end
                n = sqrt_floor(nsq);
                for (int i = 0; i < 3; i++) begin
                    u[i] = longint'((mag[i] * 16384 + n / 2) / n);
                    if (neg[i]) u[i] = -u[i];
                end
            end
            w = q[0]; x = q[1]; y = q[2]; z = q[3];
            one = 64'sd1 << 28;
            m[0][0] = one - 2 * (y * y + z * z);
            m[0][1] = 2 * (x * y - z * w);
            m[0][2] = 2 * (x * z + y * w);
            m[1][0] = 2 * (x * y + z * w);
            m[1][1] = one - 2 * (x * x + z * z);
            m[1][2] = 2 * (y * z - x * w);
            m[2][0] = 2 * (x * z - y * w);
            m[2][1] = 2 * (y * z + x * w);
            m[2][2] = one - 2 * (x * x + y * y);
            for (int i = 0; i < 3; i++)
                o[i] = to_q14(m[i][0] * u[0] + m[i][1] * u[1] + m[i][2] * u[2]);
            r.photo_number = photo_idx[7:0];
            r.unit_x = o[0][15:0];
            r.unit_y = o[1][15:0];
            r.unit_z = o[2][15:0];
            r.status = photo_idx >= n_photos;
            return r;
        endfunction

        function void note_event(logic [1:0] cmd, logic signed [15:0] gx,
                                 logic signed [15:0] gy, logic signed [15:0] gz);
            longint smp [3];
            int unsigned sk;
            case (cmd)
                CMD_SESSION: begin
                    session_no = (session_no + 1) & 9'h1FF;
                    photo_idx = 0;
                    acc[0] = 0; acc[1] = 0; acc[2] = 0;
                    n_samples = 0;
                end
                CMD_SAMPLE: begin
                    smp[0] = gx; smp[1] = gy; smp[2] = gz;
                    sk = skip_n > 16 ? 16 : skip_n;
                    if (n_samples >= sk) begin
                        for (int i = 0; i < 3; i++)
                            acc[i] = sat32(acc[i] + (sk != 0 ?
                                ring[(ring_ptr + 16 - sk) % 16][i] : smp[i]));
                    end
                    for (int i = 0; i < 3; i++) ring[ring_ptr][i] = smp[i];
                    ring_ptr = (ring_ptr + 1) % 16;
                    if (n_samples < 16) n_samples++;
                end
                CMD_PHOTO: begin
                    if (session_no == tgt_session) pending = {pending, predict_photo()};
                    if (photo_idx < 255) photo_idx++;
                    acc[0] = 0; acc[1] = 0; acc[2] = 0;
                    n_samples = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_photo_vec got);
            t_photo_vec e;
            if (pending.size() == 0) begin
                $error("unexpected result photo_number %0d", got.photo_number);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.photo_number !== e.photo_number) begin
                $error("photo_number exp %0d got %0d", e.photo_number, got.photo_number);
                errors++;
            end
            if (got.unit_x !== e.unit_x) begin
                $error("unit_x exp %0d got %0d", e.unit_x, got.unit_x);
                errors++;
            end
            if (got.unit_y !== e.unit_y) begin
                $error("unit_y exp %0d got %0d", e.unit_y, got.unit_y);
                errors++;
            end
            if (got.unit_z !== e.unit_z) begin
                $error("unit_z exp %0d got %0d", e.unit_z, got.unit_z);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gap_in_if #(.SAMPLE_BITS(16)) ev_if ();
    gap_out_if res_if ();

    gravity_average_per_photo u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (ev_if.sink),
        .o_out     (res_if.source)
    );

    gravity_scoreboard sb = new();
    bit hold_off = 1'b0;
    int seg_left = 0;
    int in_session = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        ev_if.valid = 1'b0;
        ev_if.command = CMD_SESSION;
        ev_if.grav_x = '0;
        ev_if.grav_y = '0;
        ev_if.grav_z = '0;
        res_if.ready = 1'b0;
    end

    // receiver: stall pattern, long hold-off on request
    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready)
            sb.check_result({res_if.photo_number, res_if.unit_x, res_if.unit_y,
                             res_if.unit_z, res_if.status});
        if (hold_off) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 5);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_event(logic [1:0] cmd, logic [15:0] gx, logic [15:0] gy,
                              logic [15:0] gz);
        int gap;
        if (seg_left == 0) begin
            seg_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                ev_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        seg_left--;
        ev_if.valid <= 1'b1;
        ev_if.command <= cmd;
        ev_if.grav_x <= gx;
        ev_if.grav_y <= gy;
        ev_if.grav_z <= gz;
        do @(posedge i_clk); while (!ev_if.ready);
        sb.note_event(cmd, gx, gy, gz);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        ev_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic rand_sample();
        logic [15:0] v [3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 5))
                0: v[i] = 16'h7FFF;
                1: v[i] = 16'h8000;
                2: v[i] = '0;
                default: v[i] = 16'($urandom());
            endcase
        end
        send_event(CMD_SAMPLE, v[0], v[1], v[2]);
    endtask

    task automatic rand_quat();
        logic [15:0] c [4];
        case ($urandom_range(0, 3))
            0: begin c[0] = 16'd16384; c[1] = '0; c[2] = '0; c[3] = '0; end
            1: begin
                c[0] = '0; c[1] = '0; c[2] = '0; c[3] = '0;
                c[2'($urandom_range(0, 3))] = $urandom_range(0, 1) ? 16'(-16384) : 16'd16384;
            end
            2: begin c[0] = 16'd8192; c[1] = 16'd8192; c[2] = 16'(-8192); c[3] = 16'd8192; end
            default: for (int i = 0; i < 4; i++) c[i] = 16'($urandom_range(0, 32768) - 16384);
        endcase
        write_reg(CFG_QW, c[0]);
        write_reg(CFG_QX, c[1]);
        write_reg(CFG_QY, c[2]);
        write_reg(CFG_QZ, c[3]);
    endtask

    // session: start, then a random mix of samples, photos and unused commands
    task automatic rand_session(int n_items);
        int k;
        k = 0;
        send_event(CMD_SESSION, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        in_session++;
        while (k < n_items) begin
            case ($urandom_range(0, 19))
                0: send_event(2'd3, 16'($urandom()), 16'($urandom()), 16'($urandom()));
                1, 2, 3: send_event(CMD_PHOTO, 16'($urandom()), 16'($urandom()),
                                    16'($urandom()));
                default: rand_sample();
            endcase
            k++;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, no session yet, then session 0
        send_event(CMD_PHOTO, '0, '0, '0);
        send_event(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_SESSION, '0, '0, '0);
        send_event(CMD_PHOTO, '0, '0, '0);
        send_event(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h0001);
        send_event(CMD_PHOTO, '0, '0, '0);
        for (int i = 0; i < 4; i++) send_event(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_event(CMD_PHOTO, '0, '0, '0);
        drain();
        write_reg(CFG_SKIP, 16'd31);
        write_reg(CFG_PHOTOS, 16'd2);
        write_reg(CFG_QW, 16'd0);
        write_reg(CFG_QX, 16'd16384);
        for (int i = 0; i < 17; i++) send_event(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h0100);
        send_event(CMD_PHOTO, '0, '0, '0);
        for (int i = 0; i < 3; i++) send_event(CMD_SAMPLE, 16'h1234, '0, '0);
        send_event(CMD_PHOTO, '0, '0, '0);
        drain();

        // long hold-off so the output side backs up into the input
        write_reg(CFG_SKIP, 16'd0);
        write_reg(CFG_PHOTOS, 16'd255);
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++) begin
                rand_sample();
                send_event(CMD_PHOTO, '0, '0, '0);
            end
        join
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_TARGET, (ph % 3 == 0) ? 16'(in_session + 1) :
                      16'($urandom_range(0, 255)));
            write_reg(CFG_SKIP, 16'($urandom_range(0, 2) == 0 ? 16 : $urandom_range(0, 31)));
            write_reg(CFG_PHOTOS, 16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255)));
            rand_quat();
            rand_session(85);
            drain();
        end
        // photo counter saturation
        write_reg(CFG_TARGET, 16'(in_session + 1));
        write_reg(CFG_PHOTOS, 16'd255);
        send_event(CMD_SESSION, '0, '0, '0);
        in_session++;
        for (int i = 0; i < 258; i++) send_event(CMD_PHOTO, '0, '0, '0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("gravity_average_per_photo_tb: done, clean");
        end else begin
            $display("gravity_average_per_photo_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("gravity_average_per_photo_tb: done, errors");
        $finish;
    end
endmodule
